// ===== rtl/core/lsb_pkg.sv =====
// Shared types and codes for the LSB embed/extract unit.
package lsb_pkg;

	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = 2;

	// result status codes
	localparam logic [2:0] ST_PIXEL    = 3'd0;
	localparam logic [2:0] ST_CHAR     = 3'd1;
	localparam logic [2:0] ST_BAD_LEN  = 3'd2;
	localparam logic [2:0] ST_TRUNC    = 3'd3;
	localparam logic [2:0] ST_TOO_LONG = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_MODE    = 2'd0;
	localparam logic [1:0] CFG_TOTAL   = 2'd1;
	localparam logic [1:0] CFG_MSG_LEN = 2'd2;

	typedef enum logic [1:0] {
		K_EMBED,   // pixel with its lsb replaced
		K_PASS,    // pixel unchanged
		K_CHAR,    // recovered message byte
		K_ERR      // error, data forced to zero
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_val;
		logic       bit_val;
		logic [2:0] status;
		logic       last;
	} entry_t;

endpackage

// ===== rtl/core/lsb_stego_embed_extract_unit.sv =====
// LSB steganography unit with a 32-bit length header, one image byte per input word.
// Takes one image byte every clock while in_stall is low (the queue is not full). A result
// word enters a queue slot at the edge that takes its byte, then moves to the output
// register. The four-word queue between them means a stalled sink does not stop input
// at once: in_stall rises only once four words wait behind a held output word. Embed mode
// rewrites lsbs (length header, then message bits), then passes bytes through; extract
// mode rebuilds the length and emits recovered message bytes. Either mode may emit an error
// word with last set. Bytes with no result are absorbed. Configuration is taken every cycle.
module lsb_stego_embed_extract_unit #(
	parameter int COUNT_BITS = 28
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  pixel_byte,
	input  logic        first_of_image,
	input  logic [7:0]  message_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  data_byte,
	output logic [2:0]  status,
	output logic        last
);
	import lsb_pkg::*;

	logic        mode_q;
	logic [27:0] total_q;
	logic [24:0] msg_len_q;

	logic        push;
	entry_t      push_entry;
	logic        q_full;
	logic        pop;
	logic        head_valid;
	entry_t      head_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			total_q   <= '0;
			msg_len_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:    mode_q    <= cfg_data[0];
				CFG_TOTAL:   total_q   <= cfg_data[27:0];
				CFG_MSG_LEN: msg_len_q <= cfg_data[24:0];
				default:     ;
			endcase
		end
	end

	lsb_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_byte     (pixel_byte),
		.first_of_image (first_of_image),
		.message_byte   (message_byte),
		.mode           (mode_q),
		.total_bytes    (total_q),
		.message_length (msg_len_q),
		.q_full         (q_full),
		.push           (push),
		.push_entry     (push_entry)
	);

	lsb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	lsb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.status     (status),
		.last       (last)
	);

endmodule

// ===== rtl/core/lsb_front.sv =====
// Front end: accepts image bytes, tracks header/body position, queues one word per result.
module lsb_front #(
	parameter int COUNT_BITS = 28
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      pixel_byte,
	input  logic            first_of_image,
	input  logic [7:0]      message_byte,
	input  logic            mode,
	input  logic [27:0]     total_bytes,
	input  logic [24:0]     message_length,
	input  logic            q_full,
	output logic            push,
	output lsb_pkg::entry_t push_entry
);
	import lsb_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BODY,
		PH_PASS,
		PH_HALT
	} phase_t;

	logic [COUNT_BITS-1:0] pos_q, pos_d;
	logic [31:0]           len_q, len_d;
	logic [7:0]            chr_q, chr_d;
	phase_t                phase_q, phase_d;

	logic                  accept;
	logic                  emit;
	entry_t                ent;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		logic [COUNT_BITS-1:0] p;
		logic [31:0]           len;
		logic [7:0]            chr;
		phase_t                ph;
		logic [32:0]           p_w;
		logic [32:0]           tot_w;
		logic                  final_b;
		logic [31:0]           d;
		logic [29:0]           idx1;
		logic [2:0]            k;
		logic [7:0]            c;
		logic                  bit_v;

		p      = first_of_image ? '0 : pos_q;
		len    = first_of_image ? '0 : len_q;
		chr    = first_of_image ? '0 : chr_q;
		ph     = first_of_image ? PH_HEADER : phase_q;
		p_w    = 33'(p);
		tot_w  = 33'(total_bytes);
		final_b = (p_w + 33'd1) >= tot_w;
		d      = 32'(p) - 32'd32;
		idx1   = {1'b0, d[31:3]} + 30'd1;
		k      = p[2:0];
		c      = 8'd0;
		bit_v  = 1'b0;

		pos_d   = p;
		len_d   = len;
		chr_d   = chr;
		phase_d = ph;
		emit    = 1'b0;
		ent     = '{kind: K_ERR, byte_val: 8'd0, bit_val: 1'b0, status: ST_PIXEL, last: 1'b0};

		if (!(ph == PH_HALT || p_w >= tot_w)) begin
			pos_d = p + COUNT_BITS'(1);
			if (!mode) begin
				// embed
				case (ph)
					PH_HEADER: begin
						if (p_w == 33'd0 && (26'(message_length) + 26'd4 > 26'(total_bytes[27:3]))) begin
							phase_d = PH_HALT;
							emit    = 1'b1;
							ent.status = ST_TOO_LONG;
							ent.last   = 1'b1;
						end else begin
							if (p_w == 33'd0)
								len = 32'(message_length);
							bit_v = len[0];
							len_d = len >> 1;
							if (p_w >= 33'd31)
								phase_d = (message_length != '0) ? PH_BODY : PH_PASS;
							emit = 1'b1;
							ent  = '{kind: K_EMBED, byte_val: pixel_byte, bit_val: bit_v,
								status: ST_PIXEL, last: 1'b0};
						end
					end
					PH_BODY: begin
						bit_v = message_byte[k];
						if (k == 3'd7 && 33'(idx1) >= 33'(message_length))
							phase_d = PH_PASS;
						emit = 1'b1;
						ent  = '{kind: K_EMBED, byte_val: pixel_byte, bit_val: bit_v,
							status: ST_PIXEL, last: 1'b0};
					end
					default: begin
						emit = 1'b1;
						ent  = '{kind: K_PASS, byte_val: pixel_byte, bit_val: 1'b0,
							status: ST_PIXEL, last: 1'b0};
					end
				endcase
			end else begin
				// extract
				case (ph)
					PH_HEADER: begin
						if (p_w == 33'd0)
							len = '0;
						if (p_w < 33'd32)
							len = len | ({31'd0, pixel_byte[0]} << p[4:0]);
						len_d = len;
						if (p_w >= 33'd31) begin
							if (len == '0 || 33'(len) > 33'(total_bytes[27:3])) begin
								phase_d = PH_HALT;
								emit    = 1'b1;
								ent.status = ST_BAD_LEN;
								ent.last   = 1'b1;
							end else begin
								phase_d = PH_BODY;
								chr_d   = '0;
								if (final_b) begin
									phase_d = PH_HALT;
									emit    = 1'b1;
									ent.status = ST_TRUNC;
									ent.last   = 1'b1;
								end
							end
						end else if (final_b) begin
							phase_d = PH_HALT;
							emit    = 1'b1;
							ent.status = ST_BAD_LEN;
							ent.last   = 1'b1;
						end
					end
					PH_BODY: begin
						c = chr | ({7'd0, pixel_byte[0]} << k);
						chr_d = c;
						if (k == 3'd7) begin
							chr_d = '0;
							if (33'(idx1) >= 33'(len)) begin
								phase_d = PH_HALT;
								emit    = 1'b1;
								ent     = '{kind: K_CHAR, byte_val: c, bit_val: 1'b0,
									status: ST_CHAR, last: 1'b1};
							end else if (final_b) begin
								phase_d = PH_HALT;
								emit    = 1'b1;
								ent.status = ST_TRUNC;
								ent.last   = 1'b1;
							end else begin
								emit = 1'b1;
								ent  = '{kind: K_CHAR, byte_val: c, bit_val: 1'b0,
									status: ST_CHAR, last: 1'b0};
							end
						end else if (final_b) begin
							phase_d = PH_HALT;
							emit    = 1'b1;
							ent.status = ST_TRUNC;
							ent.last   = 1'b1;
						end
					end
					default: begin
						// pass-through in extract gives nothing
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			chr_q   <= '0;
			phase_q <= PH_HEADER;
		end else if (accept) begin
			pos_q   <= pos_d;
			len_q   <= len_d;
			chr_q   <= chr_d;
			phase_q <= phase_d;
		end
	end

	assign push       = accept && emit;
	assign push_entry = ent;

endmodule

// ===== rtl/core/lsb_queue.sv =====
// Short word queue between the front end and the output stage.
module lsb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lsb_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output lsb_pkg::entry_t head_entry
);
	import lsb_pkg::*;

	entry_t               mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full       = count_q == (QPTR_BITS+1)'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/lsb_back.sv =====
// Output stage: forms the result word from a queued command and holds it for the sink.
module lsb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  lsb_pkg::entry_t head_entry,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      data_byte,
	output logic [2:0]      status,
	output logic            last
);
	import lsb_pkg::*;

	logic       out_valid_q;
	logic [7:0] data_q;
	logic [2:0] status_q;
	logic       last_q;
	logic       load;
	logic [7:0] data_n;

	assign load = !out_valid_q || !out_stall;
	assign pop  = head_valid && load;

	always_comb begin
		case (head_entry.kind)
			K_EMBED: data_n = {head_entry.byte_val[7:1], head_entry.bit_val};
			K_PASS:  data_n = head_entry.byte_val;
			K_CHAR:  data_n = head_entry.byte_val;
			default: data_n = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q   <= data_n;
			status_q <= head_entry.status;
			last_q   <= head_entry.last;
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = data_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

// ===== tb/lsb_stego_embed_extract_unit_tb.sv =====
// Self-checking testbench for the LSB steganography embed/extract unit.
module lsb_stego_embed_extract_unit_tb;
	import lsb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 10;
	localparam int ITEM_TARGET = 1150;
	localparam logic [1:0] CFG_SPARE = 2'd3;    // no register behind this index

	typedef enum logic [1:0] {P_HDR, P_BODY, P_PASS, P_HALT} eng_phase_t;

	typedef struct packed {
		logic [7:0] pix;
		logic       sof;
		logic [7:0] msg;
	} pixel_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] st;
		logic       lst;
	} out_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [31:0] cfg_data = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  pixel_byte = 8'd0;
	logic        first_of_image = 1'b0;
	logic [7:0]  message_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  data_byte;
	logic [2:0]  status;
	logic        last;

	lsb_stego_embed_extract_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_byte     (pixel_byte),
		.first_of_image (first_of_image),
		.message_byte   (message_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_byte      (data_byte),
		.status         (status),
		.last           (last)
	);

	// predictor copy of the registers and engine state
	logic        cfg_mode_m;
	logic [27:0] cfg_total_m;
	logic [24:0] cfg_len_m;
	logic [27:0] pos_r;
	logic [31:0] len_sh;
	logic [7:0]  chr_acc;
	eng_phase_t  eng_ph;

	pixel_item_t pixel_q[$];
	out_word_t   out_word_q[$];
	pixel_item_t cur_item;

	int err_cnt = 0;
	int n_queued = 0;
	int n_accepted = 0;
	int n_cfg = 0;
	int seen_by_status[5] = '{default: 0};
	int burst_left = 0;
	int gap_left = 0;
	int pat_kind = 0;
	int pat_left = 0;
	int cycle_cnt = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit lsb_engine_step(input pixel_item_t it, output out_word_t w);
		logic [31:0] p, off, tot8;
		logic [2:0]  k;
		logic [7:0]  c;
		logic        b, fin;
		w = '{8'd0, ST_PIXEL, 1'b0};
		if (it.sof) begin
			pos_r = '0;
			len_sh = '0;
			chr_acc = '0;
			eng_ph = P_HDR;
		end
		p = {4'd0, pos_r};
		if (eng_ph == P_HALT || p >= {4'd0, cfg_total_m})
			return 1'b0;
		pos_r = pos_r + 28'd1;
		fin = (p + 32'd1 >= {4'd0, cfg_total_m});
		off = p - 32'd32;
		k = off[2:0];
		tot8 = {7'd0, cfg_total_m[27:3]};

		if (!cfg_mode_m) begin
			case (eng_ph)
				P_HDR: begin
					if (p == 32'd0) begin
						if ({7'd0, cfg_len_m} + 32'd4 > tot8) begin
							eng_ph = P_HALT;
							w = '{8'd0, ST_TOO_LONG, 1'b1};
							return 1'b1;
						end
						len_sh = {7'd0, cfg_len_m};
					end
					b = len_sh[0];
					len_sh = len_sh >> 1;
					if (p >= 32'd31)
						eng_ph = (cfg_len_m != '0) ? P_BODY : P_PASS;
				end
				P_BODY: begin
					b = it.msg[k];
					if (k == 3'd7 && (off >> 3) + 32'd1 >= {7'd0, cfg_len_m})
						eng_ph = P_PASS;
				end
				default: begin
					w = '{it.pix, ST_PIXEL, 1'b0};
					return 1'b1;
				end
			endcase
			w = '{{it.pix[7:1], b}, ST_PIXEL, 1'b0};
			return 1'b1;
		end

		if (eng_ph == P_HDR) begin
			if (p == 32'd0)
				len_sh = '0;
			if (p < 32'd32)
				len_sh = len_sh | ({31'd0, it.pix[0]} << p[4:0]);
			if (p >= 32'd31) begin
				if (len_sh == '0 || len_sh > tot8) begin
					eng_ph = P_HALT;
					w = '{8'd0, ST_BAD_LEN, 1'b1};
					return 1'b1;
				end
				eng_ph = P_BODY;
				chr_acc = '0;
				if (fin) begin
					eng_ph = P_HALT;
					w = '{8'd0, ST_TRUNC, 1'b1};
					return 1'b1;
				end
				return 1'b0;
			end
			// image ends inside the header
			if (fin) begin
				eng_ph = P_HALT;
				w = '{8'd0, ST_BAD_LEN, 1'b1};
				return 1'b1;
			end
			return 1'b0;
		end
		if (eng_ph != P_BODY)
			return 1'b0;

		chr_acc = chr_acc | ({7'd0, it.pix[0]} << k);
		if (k == 3'd7) begin
			c = chr_acc;
			chr_acc = '0;
			if ((off >> 3) + 32'd1 >= len_sh) begin
				eng_ph = P_HALT;
				w = '{c, ST_CHAR, 1'b1};
				return 1'b1;
			end
			if (fin) begin
				eng_ph = P_HALT;
				w = '{8'd0, ST_TRUNC, 1'b1};
				return 1'b1;
			end
			w = '{c, ST_CHAR, 1'b0};
			return 1'b1;
		end
		if (fin) begin
			eng_ph = P_HALT;
			w = '{8'd0, ST_TRUNC, 1'b1};
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic note_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0d: %s", cycle_cnt, msg);
	endtask

	// pixel word driver: bursts with random gaps
	always @(posedge clk) begin : drv_blk
		out_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel_byte <= 8'd0;
			first_of_image <= 1'b0;
			message_byte <= 8'd0;
		end else begin
			if (in_valid && !in_stall) begin
				n_accepted++;
				if (lsb_engine_step(cur_item, w))
					out_word_q.push_back(w);
			end
			if (in_valid && in_stall) begin
				// hold the stalled word
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pixel_q.size() > 0) begin
				cur_item = pixel_q.pop_front();
				pixel_byte <= cur_item.pix;
				first_of_image <= cur_item.sof;
				message_byte <= cur_item.msg;
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 40);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor, with its own stall pattern
	always @(posedge clk) begin : mon_blk
		out_word_t got, want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_kind = $urandom_range(0, 3);
				pat_left = $urandom_range(20, 150);
			end
			pat_left--;
			case (pat_kind)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ((pat_left % 8) < 5);
			endcase

			if (out_valid && !out_stall) begin
				got = '{data_byte, status, last};
				if (got.st < 3'd5)
					seen_by_status[got.st]++;
				if (out_word_q.size() == 0) begin
					note_error($sformatf("unexpected word: data %02h status %0d last %0b",
						got.data, got.st, got.lst));
				end else begin
					want = out_word_q.pop_front();
					if (got.data !== want.data || got.st !== want.st || got.lst !== want.lst)
						note_error($sformatf(
							"mismatch: got data %02h status %0d last %0b, expected data %02h status %0d last %0b",
							got.data, got.st, got.lst, want.data, want.st, want.lst));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout with %0d words outstanding", out_word_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic push_item(input logic [7:0] pix, input logic sof, input logic [7:0] mb);
		pixel_q.push_back('{pix, sof, mb});
		n_queued++;
	endtask

	function automatic logic [7:0] rnd_pix();
		if ($urandom_range(0, 15) == 0)
			return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	// message byte held across each group of eight
	task automatic gen_embed_part(input int start, input int cnt);
		logic [7:0] mb;
		mb = 8'($urandom_range(0, 255));
		for (int i = start; i < start + cnt; i++) begin
			if (i % 8 == 0)
				mb = 8'($urandom_range(0, 255));
			push_item(rnd_pix(), i == 0, mb);
		end
	endtask

	// header lsbs carry hdr, later lsbs are random message bits
	task automatic gen_extract_part(input logic [31:0] hdr, input int start, input int cnt);
		logic b;
		for (int i = start; i < start + cnt; i++) begin
			b = (i < 32) ? hdr[i] : 1'($urandom_range(0, 1));
			push_item({7'($urandom_range(0, 127)), b}, i == 0, 8'($urandom_range(0, 255)));
		end
	endtask

	// wait until every queued word is taken and every expected result has left
	task automatic drain();
		do @(posedge clk);
		while (n_accepted != n_queued || out_word_q.size() != 0 || out_valid);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MODE:    cfg_mode_m = val[0];
			CFG_TOTAL:   cfg_total_m = val[27:0];
			CFG_MSG_LEN: cfg_len_m = val[24:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	// sometimes sets unused upper bits of the write data
	function automatic logic [31:0] cfg_word(input logic [31:0] v, input int w);
		logic [31:0] junk;
		junk = $urandom() << w;
		if ($urandom_range(0, 3) == 0)
			return v | junk;
		return v;
	endfunction

	task automatic set_cfg(input int m, input int t, input int l);
		cfg_write(CFG_MODE, cfg_word(m, 1));
		cfg_write(CFG_TOTAL, cfg_word(t, 28));
		cfg_write(CFG_MSG_LEN, cfg_word(l, 25));
	endtask

	initial begin : stim_blk
		int kind, sel, len, tot, n, n2, split, lo;
		logic [31:0] hdr;
		cfg_mode_m = 1'b0;
		cfg_total_m = '0;
		cfg_len_m = '0;
		pos_r = '0;
		len_sh = '0;
		chr_acc = '0;
		eng_ph = P_HDR;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// total of zero after reset: everything ignored, no flag seen yet
		push_item(8'h00, 1'b0, 8'h00);
		push_item(8'hFF, 1'b0, 8'hFF);
		drain();
		// largest image and longest message: too long at byte 0 even without a flag
		cfg_write(CFG_MODE, 32'd0);
		cfg_write(CFG_TOTAL, 32'h0FFF_FFFF);
		cfg_write(CFG_MSG_LEN, 32'h01FF_FFFF);
		push_item(8'hA5, 1'b0, 8'h5A);
		push_item(8'hFF, 1'b0, 8'hFF);
		push_item(8'h00, 1'b1, 8'h00);
		push_item(8'h7F, 1'b0, 8'h80);
		drain();
		// extract from an image too short for the header, then bytes past the end
		cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
		cfg_write(CFG_MODE, 32'hFFFF_FFFF);
		cfg_write(CFG_TOTAL, 32'hF000_0005);
		push_item(8'h01, 1'b1, 8'hFF);
		push_item(8'hFE, 1'b0, 8'h00);
		push_item(8'hFF, 1'b0, 8'hFF);
		push_item(8'h00, 1'b0, 8'h00);
		push_item(8'h80, 1'b0, 8'h01);
		push_item(8'h55, 1'b0, 8'hAA);
		push_item(8'hAA, 1'b0, 8'h55);
		drain();

		while (n_queued < ITEM_TARGET) begin
			kind = $urandom_range(0, 9);
			sel = $urandom_range(0, 11);
			if (kind <= 3) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
				tot = 8 * (len + 4) + $urandom_range(0, 20);
				if (sel == 0) begin
					tot = 8 * (len + 4) - $urandom_range(1, 8);
					set_cfg(0, tot, len);
					gen_embed_part(0, 3);
				end else if (sel == 1) begin
					set_cfg(0, 28'hFFF_FFFF, len);
					gen_embed_part(0, 32 + 8 * len + $urandom_range(0, 16));
				end else if (sel == 2) begin
					set_cfg(0, $urandom_range(0, 28'hFFF_FFFF), 25'h1FF_FFFF);
					gen_embed_part(0, 3);
				end else begin
					set_cfg(0, tot, len);
					repeat ($urandom_range(1, 2)) begin
						n = tot;
						case ($urandom_range(0, 7))
							0: n = $urandom_range(1, tot - 1);
							1: n = tot + $urandom_range(1, 4);
							default: ;
						endcase
						gen_embed_part(0, n);
					end
				end
			end else if (kind <= 7) begin
				len = $urandom_range(1, 5);
				hdr = len;
				tot = 32 + 8 * len + $urandom_range(0, 12);
				n = tot;
				case (sel)
					0: begin
						// message runs past the end of the image
						lo = (8 * len > 32) ? 8 * len : 32;
						tot = $urandom_range(lo, 32 + 8 * len - 1);
						n = tot;
					end
					1: begin hdr = 32'd0; n = 34; end
					2: begin hdr = tot / 8 + 1; n = 34; end
					3: begin hdr = $urandom(); n = 34; end
					4: begin tot = $urandom_range(1, 31); n = tot + $urandom_range(0, 2); end
					5: hdr = tot / 8;
					6: begin tot = 28'hFFF_FFFF; n = 32 + 8 * len + $urandom_range(0, 4); end
					7: begin hdr = 32'hFFFF_FFFF; n = 34; end
					default: ;
				endcase
				set_cfg(1, tot, $urandom_range(0, 25'h1FF_FFFF));
				repeat ($urandom_range(1, 2)) begin
					n2 = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : n;
					gen_extract_part(hdr, 0, n2);
				end
			end else if (kind == 8) begin
				// mode flips part way through an image
				len = $urandom_range(0, 2);
				tot = 8 * (len + 4) + $urandom_range(0, 16);
				set_cfg(0, tot, len);
				split = $urandom_range(1, tot - 1);
				n2 = $urandom_range(1, tot - split);
				gen_embed_part(0, split);
				drain();
				cfg_write(CFG_MODE, 32'd1);
				gen_embed_part(split, n2);
				drain();
				cfg_write(CFG_MODE, 32'd0);
				gen_embed_part(split + n2, tot - split - n2);
			end else begin
				set_cfg($urandom_range(0, 1), 0, $urandom_range(0, 5));
				gen_embed_part(0, 4);
			end
			drain();
		end

		$display("Covered %0d image bytes over %0d register writes, %0d mismatches.",
			n_accepted, n_cfg, err_cnt);
		$display("Words out: %0d pixel, %0d message, %0d bad length, %0d truncated, %0d too long.",
			seen_by_status[0], seen_by_status[1], seen_by_status[2],
			seen_by_status[3], seen_by_status[4]);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/lsb_pkg.sv
rtl/core/lsb_front.sv
rtl/core/lsb_queue.sv
rtl/core/lsb_back.sv
rtl/core/lsb_stego_embed_extract_unit.sv
tb/lsb_stego_embed_extract_unit_tb.sv
